// File: rtl/sic_pkg.sv
`timescale 1ns / 1ps
package sic_pkg;

  localparam int unsigned AtrMaxBytes = 33;
  localparam int unsigned QueueDepth  = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] line_byte;
    logic       reset_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] byte_class;
    logic       frame_end;
    logic       check_ok;
    logic       rate_update;
    logic [7:0] rate_value;
    logic [2:0] link_phase;
  } out_item_t;

  typedef enum logic [2:0] {
    PhReset    = 3'd0,
    PhWaitAtr  = 3'd1,
    PhInAtr    = 3'd2,
    PhWaitTpdu = 3'd3,
    PhInTpdu   = 3'd4,
    PhPpsReq   = 3'd5,
    PhWaitRsp  = 3'd6,
    PhPpsRsp   = 3'd7
  } phase_e;

  localparam logic [3:0] ClDiscard = 4'd0;
  localparam logic [3:0] ClAtr     = 4'd1;
  localparam logic [3:0] ClPpsReq  = 4'd2;
  localparam logic [3:0] ClPpsRsp  = 4'd3;
  localparam logic [3:0] ClHeader  = 4'd4;
  localparam logic [3:0] ClProc    = 4'd5;
  localparam logic [3:0] ClData    = 4'd6;
  localparam logic [3:0] ClStatus  = 4'd7;
  localparam logic [3:0] ClEvent   = 4'd8;

  localparam logic [7:0] DefaultRate = 8'h11;

  // Classified request handed from front to back.
  typedef struct packed {
    logic       is_event;
    logic       level;
    logic [7:0] raw;
  } work_t;

endpackage

// File: rtl/sic_front.sv
`timescale 1ns / 1ps
module sic_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sic_pkg::in_item_t in_data_i,
  output logic              push_o,
  output sic_pkg::work_t    push_data_o,
  input  logic              full_i
);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;
  always_comb begin
    push_data_o.is_event = in_data_i.kind;
    push_data_o.level    = in_data_i.reset_level;
    push_data_o.raw      = in_data_i.kind ? 8'h00 : in_data_i.line_byte;
  end
endmodule

// File: rtl/sic_queue.sv
`timescale 1ns / 1ps
module sic_queue #(
  parameter int unsigned Depth = sic_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sic_pkg::work_t push_data_i,
  output logic           full_o,
  output logic           pop_valid_o,
  output sic_pkg::work_t pop_data_o,
  input  logic           pop_i
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sic_pkg::work_t    mem_q [Depth];
  logic [Aw-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]       cnt_q, cnt_d;

  assign full_o      = (cnt_q == (Aw+1)'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

// File: rtl/sic_back.sv
`timescale 1ns / 1ps
module sic_back #(
  parameter int unsigned AtrMax = sic_pkg::AtrMaxBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  sic_pkg::work_t     pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sic_pkg::out_item_t out_data_o
);
  sic_pkg::phase_e   phase_q, phase_d;
  logic [2:0]  atr_step_q, atr_step_d, pps_step_q, pps_step_d;
  logic [3:0]  tpdu_step_q, tpdu_step_d;
  logic        inv_q, inv_d;
  logic [5:0]  atr_cnt_q, atr_cnt_d;
  logic [3:0]  hist_q, hist_d, iface_q, iface_d;
  logic [15:0] proto_q, proto_d;
  logic [7:0]  fmt_q, fmt_d, param_q, param_d, xr_q, xr_d, ins_q, ins_d, len_q, len_d;
  logic [8:0]  cnt_q, cnt_d;
  logic        ov_q;
  sic_pkg::out_item_t od_q, res;

  logic step;
  logic [7:0] b, flip;
  logic [3:0] msk;
  logic [2:0] s;
  logic       fnd, hist_done, ok;
  logic [9:0] limit;

  assign step        = pop_valid_i & (~ov_q | ~out_stall_i);
  assign pop_o       = step;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      flip[i] = ~pop_data_i.raw[7-i];
    end
  end

  always_comb begin
    phase_d = phase_q; atr_step_d = atr_step_q; pps_step_d = pps_step_q;
    tpdu_step_d = tpdu_step_q; inv_d = inv_q; atr_cnt_d = atr_cnt_q;
    hist_d = hist_q; iface_d = iface_q; proto_d = proto_q; fmt_d = fmt_q;
    param_d = param_q; xr_d = xr_q; ins_d = ins_q; len_d = len_q; cnt_d = cnt_q;
    res = '0;
    b = (inv_q && !pop_data_i.is_event) ? flip : pop_data_i.raw;
    msk = '0; s = '0; fnd = 1'b0; hist_done = 1'b0; ok = 1'b0; limit = '0;
    res.byte_class = sic_pkg::ClDiscard;
    if (pop_data_i.is_event) begin
      res.byte_class = sic_pkg::ClEvent;
      if (pop_data_i.level) begin
        phase_d = sic_pkg::PhWaitAtr;
      end else if (phase_q != sic_pkg::PhReset) begin
        phase_d = sic_pkg::PhReset;
        res.rate_update = 1'b1;
        res.rate_value = sic_pkg::DefaultRate;
      end
    end else begin
      case (phase_q)
        sic_pkg::PhWaitAtr, sic_pkg::PhInAtr: begin
          if (phase_q == sic_pkg::PhWaitAtr) begin
            phase_d = sic_pkg::PhInAtr; atr_cnt_d = '0; inv_d = 1'b0;
            proto_d = '0; atr_step_d = '0;
          end
          if ({26'd0, atr_cnt_d} < AtrMax) begin
            atr_cnt_d = atr_cnt_d + 1'b1;
            case (atr_step_d)
              3'd0: begin
                if (b == 8'h23 || b == 8'h30) begin
                  inv_d = ~inv_d; atr_step_d = 3'd1; res.byte_class = sic_pkg::ClAtr;
                end else if (b == 8'h3b || b == 8'h3f) begin
                  atr_step_d = 3'd1; res.byte_class = sic_pkg::ClAtr;
                end else begin
                  atr_cnt_d = atr_cnt_d - 1'b1;
                end
              end
              3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
                res.byte_class = sic_pkg::ClAtr;
                if (atr_step_d == 3'd1) hist_d = b[3:0];
                if (atr_step_d == 3'd5) proto_d = proto_d | (16'd1 << b[3:0]);
                if (atr_step_d == 3'd1 || atr_step_d == 3'd5) begin
                  iface_d = b[7:4]; s = 3'd0;
                end else begin
                  s = atr_step_d - 3'd1;
                end
                msk = iface_d;
                for (int i = 3; i >= 0; i--) begin
                  if (msk[i] && 3'(i) >= s) begin
                    fnd = 1'b1; atr_step_d = 3'(2 + i);
                  end
                end
                if (!fnd) begin
                  if (hist_d != '0) atr_step_d = 3'd6;
                  else hist_done = 1'b1;
                end
              end
              3'd6: begin
                res.byte_class = sic_pkg::ClAtr;
                if (hist_d != '0) hist_d = hist_d - 1'b1;
                if (hist_d == '0) hist_done = 1'b1;
              end
              3'd7: begin
                res.byte_class = sic_pkg::ClAtr;
                phase_d = sic_pkg::PhWaitTpdu; tpdu_step_d = '0; cnt_d = '0;
                res.frame_end = 1'b1;
              end
              default: ;
            endcase
            if (hist_done) begin
              if (proto_d > 16'd1) begin
                atr_step_d = 3'd7;
              end else begin
                phase_d = sic_pkg::PhWaitTpdu; tpdu_step_d = '0; cnt_d = '0;
                res.frame_end = 1'b1;
              end
            end
          end
        end
        sic_pkg::PhWaitTpdu, sic_pkg::PhWaitRsp, sic_pkg::PhInTpdu,
        sic_pkg::PhPpsReq, sic_pkg::PhPpsRsp: begin
          if ((phase_q == sic_pkg::PhWaitTpdu || phase_q == sic_pkg::PhWaitRsp)
              && b == 8'hff) begin
            phase_d = (phase_q == sic_pkg::PhWaitRsp) ? sic_pkg::PhPpsRsp : sic_pkg::PhPpsReq;
            pps_step_d = '0;
          end else if (phase_q == sic_pkg::PhWaitTpdu) begin
            phase_d = sic_pkg::PhInTpdu;
          end
          if (phase_d == sic_pkg::PhPpsReq || phase_d == sic_pkg::PhPpsRsp) begin
            res.byte_class = (phase_d == sic_pkg::PhPpsReq) ? sic_pkg::ClPpsReq
                                                            : sic_pkg::ClPpsRsp;
            case (pps_step_d)
              3'd0: begin xr_d = b; pps_step_d = 3'd1; end
              3'd1, 3'd2, 3'd3, 3'd4: begin
                xr_d = xr_d ^ b;
                if (pps_step_d == 3'd1) fmt_d = b;
                if (pps_step_d == 3'd2) param_d = b;
                s = pps_step_d - 3'd1;
                pps_step_d = 3'd5;
                for (int i = 2; i >= 0; i--) begin
                  if (fmt_d[4+i] && 3'(i) >= s) pps_step_d = 3'(2 + i);
                end
              end
              3'd5: begin
                xr_d = xr_d ^ b;
                ok = (xr_d == 8'h00);
                res.frame_end = 1'b1; res.check_ok = ok;
                if (phase_d == sic_pkg::PhPpsReq && ok) begin
                  phase_d = sic_pkg::PhWaitRsp;
                end else begin
                  if (phase_d == sic_pkg::PhPpsRsp && ok) begin
                    res.rate_update = 1'b1;
                    res.rate_value = fmt_d[4] ? param_d : sic_pkg::DefaultRate;
                  end
                  phase_d = sic_pkg::PhWaitTpdu; tpdu_step_d = '0; cnt_d = '0;
                end
              end
              default: res.byte_class = sic_pkg::ClDiscard;
            endcase
          end else if (phase_d == sic_pkg::PhInTpdu) begin
            limit = (len_q == 8'd0) ? 10'd261 : {2'b0, len_q} + 10'd5;
            case (tpdu_step_q)
              4'd0: if (b != 8'hff) begin
                cnt_d = 9'd1; tpdu_step_d = 4'd1; res.byte_class = sic_pkg::ClHeader;
              end
              4'd1, 4'd2, 4'd3, 4'd4: begin
                if (tpdu_step_q == 4'd1) ins_d = b;
                if (tpdu_step_q == 4'd4) len_d = b;
                cnt_d = {5'd0, tpdu_step_q} + 9'd1;
                tpdu_step_d = tpdu_step_q + 4'd1;
                res.byte_class = sic_pkg::ClHeader;
              end
              4'd5, 4'd8: begin
                if (tpdu_step_q == 4'd5 && b == 8'h60) begin
                  res.byte_class = sic_pkg::ClProc;
                end else if (tpdu_step_q == 4'd5 && b == ins_q) begin
                  tpdu_step_d = 4'd6; res.byte_class = sic_pkg::ClProc;
                end else if (tpdu_step_q == 4'd5 && b == ~ins_q) begin
                  tpdu_step_d = 4'd7; res.byte_class = sic_pkg::ClProc;
                end else if (b[7:4] == 4'h6 || b[7:4] == 4'h9) begin
                  cnt_d = cnt_q + 1'b1; tpdu_step_d = 4'd9;
                  res.byte_class = sic_pkg::ClStatus;
                end
              end
              4'd9: begin
                phase_d = sic_pkg::PhWaitTpdu; tpdu_step_d = '0; cnt_d = '0;
                res.frame_end = 1'b1; res.byte_class = sic_pkg::ClStatus;
              end
              4'd6, 4'd7: begin
                cnt_d = cnt_q + 1'b1;
                res.byte_class = sic_pkg::ClData;
                if (limit <= {1'b0, cnt_d}) tpdu_step_d = 4'd8;
                else if (tpdu_step_q == 4'd7) tpdu_step_d = 4'd5;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    res.byte_out = b;
    res.link_phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sic_pkg::PhReset; atr_step_q <= '0; pps_step_q <= '0;
      tpdu_step_q <= '0; inv_q <= 1'b0; atr_cnt_q <= '0; hist_q <= '0;
      iface_q <= '0; proto_q <= '0; fmt_q <= '0; param_q <= '0; xr_q <= '0;
      ins_q <= '0; len_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; atr_step_q <= atr_step_d; pps_step_q <= pps_step_d;
        tpdu_step_q <= tpdu_step_d; inv_q <= inv_d; atr_cnt_q <= atr_cnt_d;
        hist_q <= hist_d; iface_q <= iface_d; proto_q <= proto_d; fmt_q <= fmt_d;
        param_q <= param_d; xr_q <= xr_d; ins_q <= ins_d; len_q <= len_d;
        cnt_q <= cnt_d;
      end
      if (step) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) od_q <= res;
  end
endmodule

// File: rtl/smartcard_iso7816_sniffer_core.sv
`timescale 1ns / 1ps
// channel | handshake               | payload
// in      | in_valid_i/in_stall_o   | in_data_i  (sic_pkg::in_item_t)
// out     | out_valid_o/out_stall_i | out_data_o (sic_pkg::out_item_t)
// One item per cycle sustained while out_stall_i is low; a request taken is written
// into the queue, then popped into the registered parser update and result register.
// Reset clears all parser state to the reset phase; no clearing pass.
// An output stall holds the result register; the queue keeps taking requests
// until its Depth entries fill, then in_stall_o rises until the next pop.
module smartcard_iso7816_sniffer_core #(
  parameter int unsigned AtrMax = sic_pkg::AtrMaxBytes,
  parameter int unsigned Depth  = sic_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sic_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sic_pkg::out_item_t out_data_o
);
  logic           push, full, pop_valid, pop;
  sic_pkg::work_t push_data, pop_data;

  sic_front u_front (
    .in_valid_i, .in_stall_o, .in_data_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  sic_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_valid_o(pop_valid), .pop_data_o(pop_data), .pop_i(pop)
  );

  sic_back #(.AtrMax(AtrMax)) u_back (
    .clk_i, .rst_ni, .pop_valid_i(pop_valid), .pop_data_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid) else $error("pop from empty queue");
  a_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_class == sic_pkg::ClEvent |-> out_data_o.byte_out == 8'h00)
    else $error("event byte not zero");
endmodule
